>>> src/aprm_pkg.sv
// Shared types, constants and codes for the peak and RMS level meter.
// Used by every module of the block but the port checker; depends on nothing else.
`default_nettype none

package aprm_pkg;

	localparam int COUNT_WIDTH      = 24;
	localparam int DB_FRACTION_BITS = 8;

	localparam int SAMPLE_W = 16;
	localparam int SQ_W     = 31;
	localparam int SUM_W    = 54;
	localparam int WIN_W    = 24;
	localparam int LOG_FRAC = 24;
	localparam int EXP_W    = 6;
	localparam int LOG_W    = EXP_W + LOG_FRAC;
	localparam int STEP_W   = 5;
	localparam int DB_W     = 17;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int D_W      = 32;
	localparam int CMP_W    = 33;

	localparam int DB_SHIFT = LOG_FRAC + 30 - DB_FRACTION_BITS;
	localparam logic [PROD_W-1:0] DB_ROUND = PROD_W'(1) << (DB_SHIFT - 1);
	localparam logic [MUL_W-1:0] C_DB = 32'd3232284966;
	localparam logic [PROD_W-1:0] DB_FLOOR_MAG = PROD_W'(65536);
	localparam logic [DB_W-1:0] DB_FLOOR = 17'h10000;
	localparam logic signed [D_W-1:0] LOG_OFFSET = D_W'(30) <<< LOG_FRAC;
	localparam logic [EXP_W-1:0] EXP_TOP = EXP_W'(SUM_W - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LOG_FRAC - 1);
	localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd16000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RMS_EN  = 2'd2;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_STOP   = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_NORM,
		ST_MUL,
		ST_SQR,
		ST_DBMUL,
		ST_DBRES,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		JOB_PEAK,
		JOB_SUM,
		JOB_CNT
	} job_t;

	typedef struct packed {
		logic [WIN_W-1:0] window_samples;
		logic             peak_enable;
		logic             rms_enable;
	} cfg_t;

	typedef struct packed {
		logic [DB_W-1:0] peak_db;
		logic [DB_W-1:0] rms_db;
		logic            peak_valid;
		logic            rms_valid;
		logic            peak_silent;
		logic            rms_silent;
		logic            level_unknown;
	} res_t;

endpackage

`default_nettype wire

>>> src/aprm_mul.sv
// Shared 32 by 32 bit unsigned multiplier with a registered product.
// Depends on aprm_pkg for the operand and product widths.
`default_nettype none

module aprm_mul (
	input  wire logic                        clk,
	input  wire logic [aprm_pkg::MUL_W-1:0]  a,
	input  wire logic [aprm_pkg::MUL_W-1:0]  b,
	output logic      [aprm_pkg::PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= aprm_pkg::PROD_W'(a) * aprm_pkg::PROD_W'(b);
	end

endmodule

`default_nettype wire

>>> src/aprm_seq.sv
// Sequencer and datapath: accumulates squares, then runs the logarithms and
// dB scaling on the shared multiplier. Depends on aprm_pkg and aprm_mul.
`default_nettype none

module aprm_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aprm_pkg::cfg_t                cfg,
	input  wire logic                          in_valid,
	input  wire logic                          in_action,
	input  wire logic [aprm_pkg::SAMPLE_W-1:0] in_sample,
	output logic                               ready,
	input  wire logic                          out_free,
	output logic                               res_load,
	output aprm_pkg::res_t                     res,
	output logic [aprm_pkg::MUL_W-1:0]         mul_a,
	output logic [aprm_pkg::MUL_W-1:0]         mul_b,
	input  wire logic [aprm_pkg::PROD_W-1:0]   prod
);

	aprm_pkg::state_t state_q, state_d;
	aprm_pkg::job_t   job_q, job_d;

	logic [aprm_pkg::SQ_W-1:0]        peak_q;
	logic [aprm_pkg::SUM_W-1:0]       sum_q;
	logic [aprm_pkg::COUNT_WIDTH-1:0] cnt_q;

	logic [aprm_pkg::SAMPLE_W-1:0]    abs_q;
	logic [aprm_pkg::SUM_W-1:0]       x_q;
	logic [aprm_pkg::EXP_W-1:0]       e_q;
	logic [aprm_pkg::LOG_FRAC-1:0]    frac_q;
	logic [aprm_pkg::MUL_W-1:0]       m_q;
	logic [aprm_pkg::STEP_W-1:0]      step_q;
	logic signed [aprm_pkg::D_W-1:0]  d_q;
	aprm_pkg::res_t                   res_q;

	logic                             accept;
	logic                             enabled;
	logic [aprm_pkg::SAMPLE_W-1:0]    abs_in;
	logic [aprm_pkg::SQ_W-1:0]        sq;
	logic [aprm_pkg::SQ_W-1:0]        peak_n;
	logic [aprm_pkg::SUM_W-1:0]       sum_n;
	logic [aprm_pkg::COUNT_WIDTH-1:0] cnt_n;
	logic [aprm_pkg::WIN_W-1:0]       win;
	logic                             close;
	logic [aprm_pkg::MUL_W:0]         sqr;
	logic                             sqr_bit;
	logic [aprm_pkg::MUL_W-1:0]       m_n;
	logic [aprm_pkg::LOG_FRAC-1:0]    frac_n;
	logic [aprm_pkg::LOG_W-1:0]       log_val;
	logic signed [aprm_pkg::D_W-1:0]  log_ext;
	logic [aprm_pkg::MUL_W-1:0]       mag;
	logic [aprm_pkg::PROD_W-1:0]      rounded;
	logic [aprm_pkg::DB_W-1:0]        db_val;
	logic                             log_last;
	aprm_pkg::res_t                   res_stop;
	aprm_pkg::res_t                   res_win;

	assign enabled = cfg.peak_enable | cfg.rms_enable;
	assign accept  = in_valid & ready;
	assign abs_in  = in_sample[aprm_pkg::SAMPLE_W-1] ? (aprm_pkg::SAMPLE_W'(0) - in_sample)
		: in_sample;

	assign sq     = prod[aprm_pkg::SQ_W-1:0];
	assign peak_n = (cfg.peak_enable && (sq > peak_q)) ? sq : peak_q;
	assign sum_n  = cfg.rms_enable ? (sum_q + aprm_pkg::SUM_W'(sq)) : sum_q;
	assign cnt_n  = cnt_q + aprm_pkg::COUNT_WIDTH'(1);
	assign win    = (cfg.window_samples == '0) ? aprm_pkg::WIN_W'(1) : cfg.window_samples;
	assign close  = aprm_pkg::CMP_W'(cnt_n) >= aprm_pkg::CMP_W'(win);

	assign sqr      = prod[aprm_pkg::PROD_W-1:aprm_pkg::MUL_W-1];
	assign sqr_bit  = sqr[aprm_pkg::MUL_W];
	assign m_n      = sqr_bit ? sqr[aprm_pkg::MUL_W:1] : sqr[aprm_pkg::MUL_W-1:0];
	assign frac_n   = {frac_q[aprm_pkg::LOG_FRAC-2:0], sqr_bit};
	assign log_val  = {e_q, frac_n};
	assign log_ext  = $signed(aprm_pkg::D_W'(log_val));
	assign log_last = (step_q == aprm_pkg::STEP_LAST);

	assign mag     = aprm_pkg::MUL_W'(-d_q);
	assign rounded = (prod + aprm_pkg::DB_ROUND) >> aprm_pkg::DB_SHIFT;

	always_comb begin
		if (!d_q[aprm_pkg::D_W-1]) begin
			db_val = '0;
		end else if (rounded >= aprm_pkg::DB_FLOOR_MAG) begin
			db_val = aprm_pkg::DB_FLOOR;
		end else begin
			db_val = aprm_pkg::DB_W'(0) - rounded[aprm_pkg::DB_W-1:0];
		end
	end

	always_comb begin
		res_stop               = '0;
		res_stop.level_unknown = 1'b1;
		res_win                = '0;
		res_win.peak_valid     = cfg.peak_enable;
		res_win.rms_valid      = cfg.rms_enable;
		res_win.peak_silent    = cfg.peak_enable && (peak_n == '0);
		res_win.rms_silent     = cfg.rms_enable && (sum_n == '0);
		if (cfg.peak_enable && (peak_n == '0)) begin
			res_win.peak_db = aprm_pkg::DB_FLOOR;
		end
		if (cfg.rms_enable && (sum_n == '0)) begin
			res_win.rms_db = aprm_pkg::DB_FLOOR;
		end
	end

	always_comb begin
		case (state_q)
			aprm_pkg::ST_SQ: begin
				mul_a = aprm_pkg::MUL_W'(abs_q);
				mul_b = aprm_pkg::MUL_W'(abs_q);
			end
			aprm_pkg::ST_MUL: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			aprm_pkg::ST_DBMUL: begin
				mul_a = mag;
				mul_b = aprm_pkg::C_DB;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aprm_pkg::ST_IDLE;
			job_q   <= aprm_pkg::JOB_PEAK;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		ready    = 1'b0;
		res_load = 1'b0;
		case (state_q)
			aprm_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (in_valid && enabled) begin
					state_d = (in_action == aprm_pkg::ACT_STOP) ? aprm_pkg::ST_EMIT
						: aprm_pkg::ST_SQ;
				end
			end
			aprm_pkg::ST_SQ: begin
				state_d = aprm_pkg::ST_ACC;
			end
			aprm_pkg::ST_ACC: begin
				if (!close) begin
					state_d = aprm_pkg::ST_IDLE;
				end else if (cfg.peak_enable && (peak_n != '0)) begin
					state_d = aprm_pkg::ST_NORM;
					job_d   = aprm_pkg::JOB_PEAK;
				end else if (cfg.rms_enable && (sum_n != '0)) begin
					state_d = aprm_pkg::ST_NORM;
					job_d   = aprm_pkg::JOB_SUM;
				end else begin
					state_d = aprm_pkg::ST_EMIT;
				end
			end
			aprm_pkg::ST_NORM: begin
				if (x_q[aprm_pkg::SUM_W-1]) begin
					state_d = aprm_pkg::ST_MUL;
				end
			end
			aprm_pkg::ST_MUL: begin
				state_d = aprm_pkg::ST_SQR;
			end
			aprm_pkg::ST_SQR: begin
				if (!log_last) begin
					state_d = aprm_pkg::ST_MUL;
				end else if (job_q == aprm_pkg::JOB_SUM) begin
					state_d = aprm_pkg::ST_NORM;
					job_d   = aprm_pkg::JOB_CNT;
				end else begin
					state_d = aprm_pkg::ST_DBMUL;
				end
			end
			aprm_pkg::ST_DBMUL: begin
				state_d = aprm_pkg::ST_DBRES;
			end
			aprm_pkg::ST_DBRES: begin
				if ((job_q == aprm_pkg::JOB_PEAK) && cfg.rms_enable && (sum_q != '0)) begin
					state_d = aprm_pkg::ST_NORM;
					job_d   = aprm_pkg::JOB_SUM;
				end else begin
					state_d = aprm_pkg::ST_EMIT;
				end
			end
			aprm_pkg::ST_EMIT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = aprm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aprm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (res_load) begin
			peak_q <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (state_q == aprm_pkg::ST_ACC) begin
			peak_q <= peak_n;
			sum_q  <= sum_n;
			cnt_q  <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			aprm_pkg::ST_IDLE: begin
				abs_q <= abs_in;
				if (accept && (in_action == aprm_pkg::ACT_STOP)) begin
					res_q <= res_stop;
				end
			end
			aprm_pkg::ST_ACC: begin
				res_q <= res_win;
				e_q   <= aprm_pkg::EXP_TOP;
				x_q   <= (cfg.peak_enable && (peak_n != '0)) ? aprm_pkg::SUM_W'(peak_n) : sum_n;
			end
			aprm_pkg::ST_NORM: begin
				if (x_q[aprm_pkg::SUM_W-1 -: 8] == '0) begin
					x_q <= x_q << 8;
					e_q <= e_q - aprm_pkg::EXP_W'(8);
				end else if (!x_q[aprm_pkg::SUM_W-1]) begin
					x_q <= x_q << 1;
					e_q <= e_q - aprm_pkg::EXP_W'(1);
				end else begin
					m_q    <= x_q[aprm_pkg::SUM_W-1 -: aprm_pkg::MUL_W];
					frac_q <= '0;
					step_q <= '0;
				end
			end
			aprm_pkg::ST_SQR: begin
				m_q    <= m_n;
				frac_q <= frac_n;
				step_q <= step_q + aprm_pkg::STEP_W'(1);
				if (log_last) begin
					case (job_q)
						aprm_pkg::JOB_PEAK: begin
							d_q <= log_ext - aprm_pkg::LOG_OFFSET;
						end
						aprm_pkg::JOB_SUM: begin
							d_q <= log_ext - aprm_pkg::LOG_OFFSET;
							x_q <= aprm_pkg::SUM_W'(cnt_q);
							e_q <= aprm_pkg::EXP_TOP;
						end
						default: begin
							d_q <= d_q - log_ext;
						end
					endcase
				end
			end
			aprm_pkg::ST_DBRES: begin
				if (job_q == aprm_pkg::JOB_PEAK) begin
					res_q.peak_db <= db_val;
					x_q           <= sum_q;
					e_q           <= aprm_pkg::EXP_TOP;
				end else begin
					res_q.rms_db <= db_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

>>> src/audio_peak_rms_dbfs_meter.sv
// Sample word: from acceptance back to ready the sequencer squares, then accumulates.
// Window end: up to three logarithms, each a normalisation and then repeated squaring
// on the shared multiplier, and a dB scaling for each level; then the result is loaded,
// held for as long as the previous result word is still stalled at the output.
// Reset (arst_n low, asynchronous) clears the accumulators, sequencer and output valid.
`default_nettype none

module audio_peak_rms_dbfs_meter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [aprm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aprm_pkg::WIN_W-1:0]      cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// sample [15:0]
	input  wire logic [15:0]                     s_tdata,
	// action [0]
	input  wire logic                            s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// peak_db [16:0], rms_db [33:17], zeros [39:34]
	output logic [39:0]                          m_tdata,
	// peak_valid [0], rms_valid [1], peak_silent [2], rms_silent [3],
	// level_unknown [4]
	output logic [4:0]                           m_tuser
);

	aprm_pkg::cfg_t cfg_q;
	aprm_pkg::res_t res;
	aprm_pkg::res_t out_q;
	logic           m_tvalid_q;
	logic           out_free;
	logic           res_load;
	logic [aprm_pkg::MUL_W-1:0]  mul_a;
	logic [aprm_pkg::MUL_W-1:0]  mul_b;
	logic [aprm_pkg::PROD_W-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_samples <= aprm_pkg::WINDOW_RESET;
			cfg_q.peak_enable    <= 1'b1;
			cfg_q.rms_enable     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				aprm_pkg::CFG_WINDOW:  cfg_q.window_samples <= cfg_data;
				aprm_pkg::CFG_PEAK_EN: cfg_q.peak_enable    <= cfg_data[0];
				aprm_pkg::CFG_RMS_EN:  cfg_q.rms_enable     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	aprm_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	aprm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_sample (s_tdata),
		.ready     (s_tready),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.prod      (prod)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_q.rms_db, out_q.peak_db};
	assign m_tuser  = {out_q.level_unknown, out_q.rms_silent, out_q.peak_silent,
		out_q.rms_valid, out_q.peak_valid};

endmodule

`default_nettype wire

>>> src/aprm_chk.sv
// Port-level checker for the level meter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module aprm_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result word changed while stalled.");

	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> (m_tuser[3:0] == 4'b0) && (m_tdata == 40'b0))
		else $error("Stopped-stream word carries a level.");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2] || m_tuser[3]) |->
		(!m_tuser[2] || (m_tuser[0] && (m_tdata[16:0] == 17'h10000))) &&
		(!m_tuser[3] || (m_tuser[1] && (m_tdata[33:17] == 17'h10000))))
		else $error("Silent level is not at the floor.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16] || (m_tdata[15:0] == 16'b0)) &&
		(m_tdata[33] || (m_tdata[32:17] == 16'b0)) && (m_tdata[39:34] == 6'b0))
		else $error("Level above full scale.");

endmodule

bind audio_peak_rms_dbfs_meter aprm_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/meter_checker.sv
// Checker for the peak and RMS level meter: it follows the register writes, predicts the
// level word that each accepted sample or stop word causes, and compares the result words.
// Depends on aprm_pkg for the result layout, the register indexes and the action codes.

module meter_checker
	import aprm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WIN_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [15:0]          s_tdata,
	input  wire logic                 s_tuser,
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [39:0]          m_tdata,
	input  wire logic [4:0]           m_tuser,
	output int                        errors,
	output int                        pending
);

	localparam int FULL_SCALE_BITS = 30;
	localparam int SCALE_SHIFT = LOG_FRAC + FULL_SCALE_BITS - DB_FRACTION_BITS;
	localparam longint unsigned TEN_LOG2_Q30 = 64'd3232284966;

	logic [WIN_W-1:0]       window_len;
	logic                   peak_on;
	logic                   rms_on;
	logic [SQ_W-1:0]        peak_sq;
	logic [SUM_W-1:0]       sq_sum;
	logic [COUNT_WIDTH-1:0] n_count;
	res_t                   level_q[$];
	res_t                   want;
	res_t                   seen;

	// Base-two logarithm with 24 fraction bits, by repeated squaring of the mantissa.
	function automatic longint log2_fix(input logic [SUM_W-1:0] x);
		int msb;
		logic [63:0] m;
		logic [LOG_FRAC-1:0] frac;
		msb = 0;
		for (int i = 0; i < SUM_W; i++)
			if (x[i])
				msb = i;
		if (msb >= 31)
			m = 64'(x) >> (msb - 31);
		else
			m = 64'(x) << (31 - msb);
		frac = '0;
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = {frac[LOG_FRAC-2:0], 1'b0};
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (longint'(msb) << LOG_FRAC) | longint'(frac);
	endfunction

	function automatic logic [DB_W-1:0] level_to_db(input longint bits_q);
		longint unsigned mag;
		longint unsigned p;
		if (bits_q >= 0)
			return '0;
		mag = -bits_q;
		p = (mag * TEN_LOG2_Q30 + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
		if (p >= 64'd65536)
			return DB_FLOOR;
		return DB_W'(64'd0 - p);
	endfunction

	task automatic clear_windows();
		peak_sq = '0;
		sq_sum = '0;
		n_count = '0;
	endtask

	task automatic meter_step(input logic act, input logic [15:0] smp);
		res_t r;
		logic [SQ_W-1:0] sq;
		logic [WIN_W-1:0] win;
		int sv;
		r = '0;
		if (!peak_on && !rms_on)
			return;
		if (act == ACT_STOP) begin
			clear_windows();
			r.level_unknown = 1'b1;
			level_q.push_back(r);
			return;
		end
		sv = $signed(smp);
		sq = SQ_W'(sv * sv);
		if (peak_on && sq > peak_sq)
			peak_sq = sq;
		if (rms_on)
			sq_sum = sq_sum + SUM_W'(sq);
		n_count = n_count + 1'b1;
		win = (window_len == '0) ? WIN_W'(1) : window_len;
		if (WIN_W'(n_count) < win)
			return;
		if (peak_on) begin
			r.peak_valid = 1'b1;
			if (peak_sq == '0) begin
				r.peak_db = DB_FLOOR;
				r.peak_silent = 1'b1;
			end else begin
				r.peak_db = level_to_db(log2_fix(SUM_W'(peak_sq))
					- (longint'(FULL_SCALE_BITS) << LOG_FRAC));
			end
		end
		if (rms_on) begin
			r.rms_valid = 1'b1;
			if (sq_sum == '0) begin
				r.rms_db = DB_FLOOR;
				r.rms_silent = 1'b1;
			end else begin
				r.rms_db = level_to_db(log2_fix(sq_sum) - log2_fix(SUM_W'(n_count))
					- (longint'(FULL_SCALE_BITS) << LOG_FRAC));
			end
		end
		clear_windows();
		level_q.push_back(r);
	endtask

	task automatic compare_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			errors++;
		end
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len = WINDOW_RESET;
			peak_on = 1'b1;
			rms_on = 1'b1;
			clear_windows();
			level_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.peak_db = m_tdata[16:0];
				seen.rms_db = m_tdata[33:17];
				seen.peak_valid = m_tuser[0];
				seen.rms_valid = m_tuser[1];
				seen.peak_silent = m_tuser[2];
				seen.rms_silent = m_tuser[3];
				seen.level_unknown = m_tuser[4];
				if (level_q.size() == 0) begin
					$error("result word arrived with no level expected");
					errors++;
				end else begin
					want = level_q.pop_front();
					compare_field("peak_db", $signed(want.peak_db), $signed(seen.peak_db));
					compare_field("rms_db", $signed(want.rms_db), $signed(seen.rms_db));
					compare_field("peak_valid", want.peak_valid, seen.peak_valid);
					compare_field("rms_valid", want.rms_valid, seen.rms_valid);
					compare_field("peak_silent", want.peak_silent, seen.peak_silent);
					compare_field("rms_silent", want.rms_silent, seen.rms_silent);
					compare_field("level_unknown", want.level_unknown, seen.level_unknown);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW: begin
						window_len = cfg_data;
					end
					CFG_PEAK_EN: begin
						peak_on = cfg_data[0];
					end
					CFG_RMS_EN: begin
						rms_on = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				meter_step(s_tuser, s_tdata);
			pending <= level_q.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the level meter testbench: clock, reset, register writes, sample and stop words
// with bursty sending and a stalling receiver, a watchdog, and the final verdict.
// Depends on aprm_pkg, audio_peak_rms_dbfs_meter and meter_checker.

module tb_top;
	import aprm_pkg::*;

	localparam int SETTLE_CYCLES = 250;
	localparam int QUIET_LIMIT = 4000;
	localparam int WORD_TARGET = 500;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WIN_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [39:0]          m_tdata;
	logic [4:0]           m_tuser;

	int         check_errors;
	int         open_levels;
	int         burst_left = 0;
	int         words_sent = 0;
	int         quiet_cycles = 0;
	int         stall_mode = 0;
	logic [7:0] stall_tick = '0;

	audio_peak_rms_dbfs_meter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	meter_checker level_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (check_errors),
		.pending   (open_levels)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver changes its stall pattern each time the low seven bits of its tick counter return to zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (stall_tick[6:0] == '0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_tick[3:0] < 4'd5);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_meter(input logic [WIN_W-1:0] win, input logic pk, input logic rm);
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_PEAK_EN, WIN_W'(pk));
		write_reg(CFG_RMS_EN, WIN_W'(rm));
	endtask

	task automatic send_word(input logic act, input logic [15:0] smp);
		if (burst_left == 0) begin
			if (s_tvalid) begin
				s_tvalid <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(20, 300)) @(posedge clk);
				else
					repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= smp;
		do
			@(posedge clk);
		while (!s_tready);
		burst_left--;
	endtask

	// Waits until every expected level word has arrived and the block has gone quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (open_levels != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 32)) - 16);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [WIN_W-1:0] win;
		logic pk;
		logic rm;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default window: a few samples, then a stop word reports unknown levels.
		send_word(ACT_SAMPLE, 16'd1000);
		send_word(ACT_SAMPLE, -16'd3);
		send_word(ACT_SAMPLE, 16'h7FFF);
		send_word(ACT_STOP, 16'h5A5A);
		settle();

		// A zero window behaves as one sample, so every sample gives a level word.
		set_meter('0, 1'b1, 1'b1);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'h7FFF);
		send_word(ACT_SAMPLE, 16'h8000);
		send_word(ACT_SAMPLE, 16'h0001);
		send_word(ACT_SAMPLE, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'h5555);
		settle();

		set_meter(24'd2, 1'b1, 1'b0);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'd100);
		send_word(ACT_SAMPLE, -16'd5);
		settle();

		set_meter(24'd3, 1'b0, 1'b1);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'h0000);
		send_word(ACT_SAMPLE, 16'h8000);
		send_word(ACT_SAMPLE, 16'hAAAA);
		settle();

		// With both measures off the block ignores every word.
		set_meter(24'd1, 1'b0, 1'b0);
		send_word(ACT_SAMPLE, 16'h1234);
		send_word(ACT_SAMPLE, 16'h8000);
		send_word(ACT_STOP, 16'h0000);
		settle();

		// Window lowered and RMS switched off part-way through a window.
		set_meter(24'd20, 1'b1, 1'b1);
		repeat (6) send_word(ACT_SAMPLE, pick_sample());
		settle();
		set_meter(24'd5, 1'b1, 1'b0);
		send_word(ACT_SAMPLE, 16'h4000);
		settle();

		set_meter(24'hFFFFFF, 1'b1, 1'b1);
		send_word(ACT_SAMPLE, 16'h7FFF);
		send_word(ACT_SAMPLE, 16'h8001);
		send_word(ACT_STOP, 16'hFFFF);
		settle();

		while (words_sent < WORD_TARGET) begin
			case ($urandom_range(0, 9))
				0: win = '0;
				1, 2, 3, 4, 5: win = $urandom_range(1, 8);
				6, 7: win = $urandom_range(9, 40);
				8: win = $urandom_range(41, 200);
				default: win = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF
					: WIN_W'($urandom_range(201, 1000));
			endcase
			pk = $urandom_range(0, 1);
			rm = $urandom_range(0, 1);
			if (!pk && !rm && $urandom_range(0, 3) != 0)
				pk = 1'b1;
			set_meter(win, pk, rm);
			n = (pk || rm) ? $urandom_range(10, 60) : 8;
			repeat (n) begin
				send_word(($urandom_range(0, 39) == 0) ? ACT_STOP : ACT_SAMPLE, pick_sample());
				if (pk || rm)
					words_sent++;
			end
			settle();
		end

		if (check_errors == 0 && open_levels == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> audio_peak_rms_dbfs_meter.f
src/aprm_pkg.sv
src/aprm_mul.sv
src/aprm_seq.sv
src/audio_peak_rms_dbfs_meter.sv
src/aprm_chk.sv
tb/meter_checker.sv
tb/tb_top.sv
